/* sv/pbe_pkg.sv */
// Shared types and constants of the polynomial basis expander.
`default_nettype none
package pbe_pkg;

  // Fixed-point format of coordinates and terms
  localparam int FRAC_BITS = 12;
  localparam int MAX_DIMS  = 3;

  localparam int COORD_W = 16;
  localparam int TIDX_W  = 6;
  localparam int DEG_W   = 3;
  localparam int DIMS_W  = 2;

  // Two-entry command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [COORD_W-1:0] ONE     = COORD_W'(1 << FRAC_BITS);
  localparam logic signed [COORD_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 16'sh8000;

  // Register indexes of the configuration port
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_DIMS   = 1'b1;

  localparam logic [DEG_W-1:0]  DEGREE_RESET = 3'd1;
  localparam logic [DIMS_W-1:0] DIMS_RESET   = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] basis_value;
    logic [TIDX_W-1:0]         term_index;
    logic                      is_last;
  } out_word_t;

  // One classified command: point plus the effective degree and dimension count
  typedef struct packed {
    in_word_t          pt;
    logic [DEG_W-1:0]  deg;
    logic [DIMS_W-1:0] dims;
  } item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CONST,
    PH_LIN,
    PH_DFS
  } phase_t;

endpackage
`default_nettype wire

/* sv/pbe_front.sv */
// Front end: configuration registers, command acceptance and classification.
`default_nettype none
module pbe_front #(
  parameter int MAX_DEGREE = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  input  wire logic             start,
  output logic                  busy,
  input  wire pbe_pkg::in_word_t point,
  input  wire pbe_pkg::q_stat_t q_stat,
  output logic                  push,
  output pbe_pkg::item_t        push_data
);

  logic [pbe_pkg::DEG_W-1:0]  degree;
  logic [pbe_pkg::DIMS_W-1:0] dims_in_use;
  logic [pbe_pkg::DEG_W-1:0]  deg_eff;
  logic [pbe_pkg::DIMS_W-1:0] dims_eff;
  logic                       held;
  logic                       accept;
  logic                       cfg_wr;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= pbe_pkg::DEGREE_RESET;
      dims_in_use <= pbe_pkg::DIMS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == pbe_pkg::REG_DEGREE) begin
        degree <= pwdata[pbe_pkg::DEG_W-1:0];
      end else begin
        dims_in_use <= pwdata[pbe_pkg::DIMS_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pbe_pkg::REG_DIMS) begin
      prdata = {{(32-pbe_pkg::DIMS_W){1'b0}}, dims_in_use};
    end else begin
      prdata = {{(32-pbe_pkg::DEG_W){1'b0}}, degree};
    end
  end

  // Clamp the registers into the supported range
  always_comb begin
    if (degree == '0) begin
      deg_eff = pbe_pkg::DEG_W'(1);
    end else if (degree > pbe_pkg::DEG_W'(MAX_DEGREE)) begin
      deg_eff = pbe_pkg::DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = degree;
    end
    if (dims_in_use == '0) begin
      dims_eff = pbe_pkg::DIMS_W'(1);
    end else if (dims_in_use > pbe_pkg::DIMS_W'(pbe_pkg::MAX_DIMS)) begin
      dims_eff = pbe_pkg::DIMS_W'(pbe_pkg::MAX_DIMS);
    end else begin
      dims_eff = dims_in_use;
    end
  end

  assign push   = held && !q_stat.full;
  assign busy   = held && q_stat.full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_data.pt   <= point;
      push_data.deg  <= deg_eff;
      push_data.dims <= dims_eff;
    end
  end

endmodule
`default_nettype wire

/* sv/pbe_queue.sv */
// Small command queue between the front end and the term generator.
`default_nettype none
module pbe_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pbe_pkg::item_t   push_data,
  input  wire logic             pop,
  output pbe_pkg::item_t        pop_data,
  output pbe_pkg::q_stat_t      q_stat
);

  localparam int PTR_W = $clog2(pbe_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pbe_pkg::QUEUE_DEPTH + 1);

  pbe_pkg::item_t   entries [pbe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count == CNT_W'(pbe_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = entries[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_data;
    end
  end

  // Depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + PTR_W'(1);
      end
      if (do_pop) begin
        rp <= rp + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/pbe_back.sv */
// Term generator: walks the monomial tree and emits one term per cycle.
`default_nettype none
module pbe_back #(
  parameter int MAX_DEGREE = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pbe_pkg::q_stat_t q_stat,
  input  wire pbe_pkg::item_t   q_data,
  output logic                  pop,
  output logic                  term_valid,
  output pbe_pkg::out_word_t    term
);

  localparam int LVL_W = $clog2(MAX_DEGREE + 1);
  localparam int CW    = pbe_pkg::COORD_W;
  localparam int IW    = pbe_pkg::DIMS_W;

  function automatic logic signed [CW-1:0] coord_sel(input pbe_pkg::in_word_t p,
                                                     input logic [IW-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      2'd0:    r = p.coord_0;
      2'd1:    r = p.coord_1;
      default: r = p.coord_2;
    endcase
    return r;
  endfunction

  // Rescale with floor and clamp to 16 bits
  function automatic logic signed [CW-1:0] rescale(input logic signed [2*CW-1:0] p);
    logic signed [2*CW-1:0] q;
    logic signed [CW-1:0]   r;
    q = p >>> pbe_pkg::FRAC_BITS;
    if (q > 32'sd32767) begin
      r = pbe_pkg::SAT_MAX;
    end else if (q < -32'sd32768) begin
      r = pbe_pkg::SAT_MIN;
    end else begin
      r = q[CW-1:0];
    end
    return r;
  endfunction

  pbe_pkg::phase_t              phase;
  pbe_pkg::phase_t              phase_next;
  pbe_pkg::item_t               cur;
  logic [LVL_W-1:0]             lvl;
  logic [IW-1:0]                idx_cur;
  logic [IW-1:0]                idx [MAX_DEGREE+1];
  logic signed [CW-1:0]         val [MAX_DEGREE+1];
  logic signed [CW-1:0]         par;
  logic [pbe_pkg::TIDX_W-1:0]   tidx;

  logic                         emit;
  logic                         fin;
  logic signed [CW-1:0]         value;
  logic signed [CW-1:0]         coord;
  logic signed [2*CW-1:0]       prod;
  logic signed [CW-1:0]         prod_sat;
  logic [IW-1:0]                dims_last;
  logic                         leaf;
  logic                         found;
  logic [LVL_W-1:0]             tgt;
  logic [IW-1:0]                tgt_idx;
  logic signed [CW-1:0]         tgt_par;
  logic [IW-1:0]                i_new;
  logic                         load;

  assign dims_last = cur.dims - IW'(1);
  assign coord     = coord_sel(cur.pt, idx_cur);
  assign prod      = par * coord;
  assign prod_sat  = rescale(prod);
  assign leaf      = (lvl == LVL_W'(cur.deg));
  assign i_new     = idx[1] + IW'(1);

  // Deepest open ancestor level that still has a sibling to visit
  always_comb begin
    found   = 1'b0;
    tgt     = LVL_W'(1);
    tgt_idx = '0;
    tgt_par = '0;
    for (int l = 1; l < MAX_DEGREE; l++) begin
      if (LVL_W'(l) < lvl && idx[l] != dims_last) begin
        found = 1'b1;
        tgt   = LVL_W'(l);
      end
    end
    for (int l = 2; l < MAX_DEGREE; l++) begin
      if (LVL_W'(l) == tgt) begin
        tgt_idx = idx[l];
        tgt_par = val[l-1];
      end
    end
  end

  // Term output of the current step
  always_comb begin
    emit  = 1'b0;
    fin   = 1'b0;
    value = '0;
    case (phase)
      pbe_pkg::PH_CONST: begin
        emit  = 1'b1;
        value = pbe_pkg::ONE;
      end
      pbe_pkg::PH_LIN: begin
        emit  = 1'b1;
        value = coord;
        fin   = (idx_cur == dims_last) && (cur.deg == pbe_pkg::DEG_W'(1));
      end
      pbe_pkg::PH_DFS: begin
        emit  = 1'b1;
        value = prod_sat;
        fin   = leaf && (idx_cur == dims_last) && !found;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign load = ((phase == pbe_pkg::PH_IDLE) || fin) && !q_stat.empty;
  assign pop  = load;

  always_comb begin
    phase_next = phase;
    case (phase)
      pbe_pkg::PH_IDLE: begin
        if (!q_stat.empty) begin
          phase_next = pbe_pkg::PH_CONST;
        end
      end
      pbe_pkg::PH_CONST: begin
        phase_next = pbe_pkg::PH_LIN;
      end
      pbe_pkg::PH_LIN, pbe_pkg::PH_DFS: begin
        if (fin) begin
          phase_next = q_stat.empty ? pbe_pkg::PH_IDLE : pbe_pkg::PH_CONST;
        end else if (phase == pbe_pkg::PH_LIN && idx_cur == dims_last) begin
          phase_next = pbe_pkg::PH_DFS;
        end
      end
      default: begin
        phase_next = pbe_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pbe_pkg::PH_IDLE;
      term_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      term_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    term.basis_value <= value;
    term.term_index  <= tidx;
    term.is_last     <= fin;
    if (load) begin
      cur     <= q_data;
      tidx    <= '0;
      idx_cur <= '0;
    end else begin
      if (emit) begin
        tidx <= tidx + pbe_pkg::TIDX_W'(1);
      end
      if (phase == pbe_pkg::PH_LIN && !fin) begin
        if (idx_cur != dims_last) begin
          idx_cur <= idx_cur + IW'(1);
        end else begin
          // Open the tree at the first coordinate
          lvl     <= LVL_W'(2);
          idx[1]  <= '0;
          val[1]  <= cur.pt.coord_0;
          par     <= cur.pt.coord_0;
          idx_cur <= '0;
        end
      end
      if (phase == pbe_pkg::PH_DFS && !fin) begin
        val[lvl] <= prod_sat;
        idx[lvl] <= idx_cur;
        if (!leaf) begin
          lvl <= lvl + LVL_W'(1);
          par <= prod_sat;
        end else if (idx_cur != dims_last) begin
          idx_cur <= idx_cur + IW'(1);
        end else if (tgt == LVL_W'(1)) begin
          idx[1]  <= i_new;
          val[1]  <= coord_sel(cur.pt, i_new);
          par     <= coord_sel(cur.pt, i_new);
          lvl     <= LVL_W'(2);
          idx_cur <= i_new;
        end else begin
          lvl     <= tgt;
          idx_cur <= tgt_idx + IW'(1);
          par     <= tgt_par;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/polynomial_basis_expander_unit.sv */
// Top level of the polynomial basis expander.
`default_nettype none
// Polynomial basis expander. Pulse start with a point on the point port while
// busy is low and the block emits every monomial of the complete polynomial of
// the configured degree over the configured number of coordinates: first the
// constant 1.0, then each coordinate, then the higher-degree terms in
// depth-first order, each the previous term of its branch times a coordinate,
// rescaled by flooring and saturated to signed Q3.12. Each term appears for
// exactly one cycle with term_valid high and must be taken then: there is no
// backpressure on the output side. The last term of a point has is_last set.
// A point produces C(dims + degree, degree) terms, between 2 and 56, one per
// clock cycle; the term generator, with its single 16x16 multiplier used once
// per higher-degree term, sets that rate. Commands wait in a two-entry queue
// plus a holding register in the front end, so up to three points are taken
// ahead of the generator and consecutive points come out without a gap; busy
// rises only once that buffering is full. The first term of a point accepted
// into an idle block passes the holding register, the queue, the generator
// load and the output register before it appears.
// Configuration: register 0 (byte address 0) is degree, register 1 (byte
// address 4) is dims_in_use; write them only while the block is idle.
// Out-of-range values are clamped into 1..MAX_DEGREE and 1..3.
module polynomial_basis_expander_unit #(
  parameter int MAX_DEGREE = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire pbe_pkg::in_word_t point,
  output logic                   term_valid,
  output pbe_pkg::out_word_t     term
);

  pbe_pkg::q_stat_t q_stat;
  pbe_pkg::item_t   push_data;
  pbe_pkg::item_t   pop_data;
  logic             push;
  logic             pop;

  // Register writes always complete in the access cycle
  assign pready = 1'b1;

  // Front end: hold the accepted word and classify it with the current config
  pbe_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple acceptance from term generation
  pbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back end: walk the term tree, one multiply and one term per cycle
  pbe_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_data     (pop_data),
    .pop        (pop),
    .term_valid (term_valid),
    .term       (term)
  );

endmodule
`default_nettype wire

/* dv/pbe_tb_pkg.sv */
`timescale 1ns / 1ps
// Term predictor and checker for the polynomial basis expander testbench.
package pbe_tb_pkg;
  import pbe_pkg::*;

  class basis_term_checker;
    logic [DEG_W-1:0]           degree_reg;
    logic [DIMS_W-1:0]          dims_reg;
    int                         max_degree;
    int                         n_deg;
    int                         n_dims;
    logic signed [COORD_W-1:0]  coords[MAX_DIMS];
    out_word_t                  pending_terms[$];
    int                         term_count;
    int                         mismatch_count;

    function new(int max_deg);
      max_degree     = max_deg;
      degree_reg     = DEGREE_RESET;
      dims_reg       = DIMS_RESET;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_DEGREE)
        degree_reg = data[DEG_W-1:0];
      else
        dims_reg = data[DIMS_W-1:0];
    endfunction

    // Q3.12 multiply: floor rescale, then saturate to 16 bits.
    function logic signed [COORD_W-1:0] scale_mul(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
      logic signed [31:0] prod;
      logic signed [31:0] q;
      prod = a * b;
      q = prod >>> FRAC_BITS;
      if (q > SAT_MAX)
        return SAT_MAX;
      if (q < SAT_MIN)
        return SAT_MIN;
      return q[COORD_W-1:0];
    endfunction

    function void push_term(logic signed [COORD_W-1:0] v);
      out_word_t w;
      w.basis_value = v;
      w.term_index  = TIDX_W'(term_count);
      w.is_last     = 1'b0;
      pending_terms.push_back(w);
      term_count++;
    endfunction

    // Depth-first walk over nondecreasing coordinate indexes.
    function void extend(logic signed [COORD_W-1:0] parent, int first, int level);
      logic signed [COORD_W-1:0] v;
      for (int j = first; j < n_dims; j++) begin
        v = scale_mul(parent, coords[j]);
        push_term(v);
        if (level < n_deg)
          extend(v, j, level + 1);
      end
    endfunction

    function void note_point(in_word_t p);
      n_deg  = int'(degree_reg);
      n_dims = int'(dims_reg);
      if (n_deg < 1) n_deg = 1;
      if (n_deg > max_degree) n_deg = max_degree;
      if (n_dims < 1) n_dims = 1;
      if (n_dims > MAX_DIMS) n_dims = MAX_DIMS;
      coords[0]  = p.coord_0;
      coords[1]  = p.coord_1;
      coords[2]  = p.coord_2;
      term_count = 0;
      push_term(ONE);
      for (int i = 0; i < n_dims; i++)
        push_term(coords[i]);
      if (n_deg >= 2)
        for (int i = 0; i < n_dims; i++)
          extend(coords[i], i, 2);
      pending_terms[pending_terms.size()-1].is_last = 1'b1;
    endfunction

    function void check_term(out_word_t got);
      out_word_t want;
      if (pending_terms.size() == 0) begin
        $error("term arrived with none expected: basis_value %0d term_index %0d",
               got.basis_value, got.term_index);
        mismatch_count++;
        return;
      end
      want = pending_terms.pop_front();
      if (got.basis_value !== want.basis_value) begin
        $error("basis_value: expected %0d, actual %0d", want.basis_value, got.basis_value);
        mismatch_count++;
      end
      if (got.term_index !== want.term_index) begin
        $error("term_index: expected %0d, actual %0d", want.term_index, got.term_index);
        mismatch_count++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_terms.size();
    endfunction
  endclass

endpackage

/* dv/tb_polynomial_basis_expander_unit.sv */
`timescale 1ns / 1ps
// Testbench top of the polynomial basis expander: directed and random points.
module tb_polynomial_basis_expander_unit;
  import pbe_pkg::*;
  import pbe_tb_pkg::*;

  localparam int MAX_DEGREE  = 5;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 50;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  in_word_t    point;
  logic        term_valid;
  out_word_t   term;

  basis_term_checker terms_sb = new(MAX_DEGREE);

  polynomial_basis_expander_unit #(
    .MAX_DEGREE(MAX_DEGREE)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .term_valid(term_valid),
    .term      (term)
  );

  always #5 clk = ~clk;

  // Terms cannot be stalled: take every word flagged by term_valid. Values read
  // right after the edge are the ones the edge saw, since the block updates
  // its outputs with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && term_valid)
      terms_sb.check_term(term);
  end

  // Present one point and hold start until the block takes it. Leave start
  // high afterwards so back-to-back words need no second assignment.
  task automatic send_point(in_word_t p);
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    terms_sb.note_point(p);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and wait until every expected term has come out, then let the
  // pipeline settle before the next register write.
  task automatic drain_terms();
    start <= 1'b0;
    do @(posedge clk); while (terms_sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access until pready. Leave psel high;
  // the caller closes the transfer sequence.
  task automatic write_reg(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    terms_sb.write_reg(idx, data);
  endtask

  // Write both registers; upper data bits carry junk the block must ignore.
  task automatic configure(logic [DEG_W-1:0] deg, logic [DIMS_W-1:0] dims);
    write_reg(REG_DEGREE, {29'($urandom), deg});
    write_reg(REG_DIMS, {30'($urandom), dims});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mix full-range noise, values near unity (so products stay in range and
  // deep terms carry information), and the saturation corners.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      return COORD_W'($urandom);
    if (pick < 8) begin
      v = int'($urandom_range(0, 4 * int'(ONE))) - 2 * int'(ONE);
      return COORD_W'(v);
    end
    case ($urandom_range(0, 4))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return ONE;
      3:       return -ONE;
      default: return '0;
    endcase
  endfunction

  function automatic in_word_t rand_point();
    in_word_t p;
    p.coord_0 = rand_coord();
    p.coord_1 = rand_coord();
    p.coord_2 = rand_coord();
    return p;
  endfunction

  function automatic in_word_t mk_point(logic signed [COORD_W-1:0] a,
                                        logic signed [COORD_W-1:0] b,
                                        logic signed [COORD_W-1:0] c);
    in_word_t p;
    p.coord_0 = a;
    p.coord_1 = b;
    p.coord_2 = c;
    return p;
  endfunction

  // Random phase: new register settings, then a run of points with idle
  // bursts at the given rate.
  task automatic random_phase(logic [DEG_W-1:0] deg, logic [DIMS_W-1:0] dims,
                              int idle_pct);
    configure(deg, dims);
    for (int k = 0; k < PHASE_WORDS; k++) begin
      send_point(rand_point());
      if ($urandom_range(0, 99) < idle_pct)
        idle_sender($urandom_range(1, 7));
    end
    drain_terms();
  endtask

  initial begin
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    start   <= 1'b0;
    point   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: degree one over all three coordinates.
    send_point(mk_point(ONE, -ONE, 16'sh1234));
    send_point(mk_point(SAT_MIN, SAT_MAX, '0));
    drain_terms();

    // Full basis with the corner values; saturation feeds the deeper terms.
    configure(3'd5, 2'd3);
    send_point(mk_point(SAT_MAX, SAT_MAX, SAT_MAX));
    send_point(mk_point(SAT_MIN, SAT_MIN, SAT_MIN));
    send_point(mk_point('0, '0, '0));
    send_point(mk_point(ONE, ONE, ONE));
    send_point(mk_point(-ONE, SAT_MIN, SAT_MAX));
    send_point(mk_point(16'sh0001, -16'sh0001, 16'sh1800));
    drain_terms();

    // Zero in both registers: clamps to degree one, one coordinate.
    configure(3'd0, 2'd0);
    send_point(mk_point(SAT_MIN, SAT_MAX, ONE));
    send_point(mk_point(16'sh5a5a, 16'sha5a5, '0));
    drain_terms();

    // Degree above the maximum clamps down.
    configure(3'd7, 2'd2);
    send_point(mk_point(16'sh1800, -16'sh2000, SAT_MAX));
    send_point(mk_point(SAT_MAX, SAT_MIN, SAT_MIN));
    drain_terms();

    configure(3'd6, 2'd1);
    send_point(mk_point(-16'sh1800, SAT_MAX, SAT_MIN));
    send_point(mk_point(SAT_MIN, '0, '0));
    drain_terms();

    configure(3'd2, 2'd3);
    send_point(mk_point(16'sh2000, -16'sh0800, 16'sh0fff));
    send_point(mk_point(SAT_MAX, SAT_MIN, -ONE));
    drain_terms();

    configure(3'd3, 2'd2);
    send_point(mk_point(-16'sh1000, 16'sh3000, SAT_MIN));
    send_point(mk_point(16'sh0800, 16'sh0800, 16'sh0800));
    drain_terms();

    configure(3'd4, 2'd1);
    send_point(mk_point(16'sh1fff, SAT_MIN, SAT_MAX));
    send_point(mk_point(-16'sh1400, '0, '0));
    drain_terms();

    // Random part: mostly in-range settings, some out of range; every third
    // phase runs without idle cycles. The last phase runs the widest
    // basis back to back with no idling.
    for (int ph = 0; ph < RAND_PHASES - 1; ph++) begin
      if (ph % 4 == 3)
        random_phase(DEG_W'($urandom_range(0, 7)), DIMS_W'($urandom_range(0, 3)),
                     (ph % 3 == 1) ? 0 : 35);
      else
        random_phase(DEG_W'($urandom_range(1, 5)), DIMS_W'($urandom_range(1, 3)),
                     (ph % 3 == 1) ? 0 : 35);
    end
    random_phase(3'd5, 2'd3, 0);

    repeat (10) @(posedge clk);
    if (terms_sb.mismatch_count == 0 && terms_sb.pending() == 0)
      $display("[polynomial_basis_expander_unit] OK");
    else
      $display("[polynomial_basis_expander_unit] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("[polynomial_basis_expander_unit] ERROR");
    $finish;
  end

endmodule
